FILE: hdl/bdq_pkg.sv
package bdq_pkg;

  localparam int DEPTH  = 32;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int WORD_W = 32;
  localparam int ACT_W  = 3;
  localparam int KIND_W = 3;
  localparam int CLS_W  = 3;

  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_OCC  = CW'(DEPTH);

  localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_POP_BACK   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_DISPLAY    = 3'd4;
  localparam logic [ACT_W-1:0] ACT_COUNT      = 3'd5;
  localparam logic [ACT_W-1:0] ACT_SEARCH     = 3'd6;

  localparam logic [KIND_W-1:0] K_ENTRY  = 3'd0;
  localparam logic [KIND_W-1:0] K_COUNT  = 3'd1;
  localparam logic [KIND_W-1:0] K_FOUND  = 3'd2;
  localparam logic [KIND_W-1:0] K_ABSENT = 3'd3;
  localparam logic [KIND_W-1:0] K_EMPTY  = 3'd4;
  localparam logic [KIND_W-1:0] K_FULL   = 3'd5;

  localparam logic [CLS_W-1:0] CLS_NONE   = 3'd0;
  localparam logic [CLS_W-1:0] CLS_PUSH   = 3'd1;
  localparam logic [CLS_W-1:0] CLS_POP    = 3'd2;
  localparam logic [CLS_W-1:0] CLS_LIST   = 3'd3;
  localparam logic [CLS_W-1:0] CLS_SEARCH = 3'd4;

  typedef struct packed {
    logic [CLS_W-1:0]  cls;
    logic              at_front;
    logic              with_count;
    logic [WORD_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [WORD_W-1:0] data;
    logic              last;
  } res_t;

endpackage

FILE: hdl/bdq_front.sv
module bdq_front import bdq_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [ACT_W-1:0]  action,
  input  logic [WORD_W-1:0] value,
  output logic              cmd_valid,
  input  logic              cmd_take,
  output cmd_t              cmd
);

  cmd_t       slots [2];
  cmd_t       cls_cmd;
  logic       wp;
  logic       rp;
  logic [1:0] fill;
  logic       wr;
  logic       rd;

  always_comb begin
    cls_cmd.value      = value;
    cls_cmd.at_front   = 1'b0;
    cls_cmd.with_count = 1'b0;
    unique case (action)
      ACT_PUSH_FRONT: begin
        cls_cmd.cls      = CLS_PUSH;
        cls_cmd.at_front = 1'b1;
      end
      ACT_PUSH_BACK: cls_cmd.cls = CLS_PUSH;
      ACT_POP_FRONT: begin
        cls_cmd.cls      = CLS_POP;
        cls_cmd.at_front = 1'b1;
      end
      ACT_POP_BACK: cls_cmd.cls = CLS_POP;
      ACT_DISPLAY:  cls_cmd.cls = CLS_LIST;
      ACT_COUNT: begin
        cls_cmd.cls        = CLS_LIST;
        cls_cmd.with_count = 1'b1;
      end
      ACT_SEARCH: cls_cmd.cls = CLS_SEARCH;
      default:    cls_cmd.cls = CLS_NONE;
    endcase
  end

  assign full      = (fill == 2'd2);
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = slots[rp];
  assign wr        = push && !full;
  assign rd        = cmd_take && cmd_valid;

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wp] <= cls_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (wr) begin
        wp <= !wp;
      end
      if (rd) begin
        rp <= !rp;
      end
      if (wr && !rd) begin
        fill <= fill + 2'd1;
      end else if (rd && !wr) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

FILE: hdl/bdq_back.sv
module bdq_back import bdq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_take,
  input  cmd_t cmd,
  input  logic res_full,
  output logic res_push,
  output res_t res
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RES  = 2'd1;
  localparam logic [1:0] S_RD   = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rdata;

  logic [1:0]    state, state_next;
  logic [AW-1:0] front_idx, front_idx_next;
  logic [CW-1:0] occ, occ_next;
  logic [AW-1:0] slot, slot_next;
  logic [AW-1:0] cnt, cnt_next;
  cmd_t          cur, cur_next;
  res_t          pend, pend_next;

  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [CW:0]   tail_sum;
  logic [AW-1:0] tail;
  logic [AW-1:0] front_prev;
  logic [AW-1:0] front_succ;
  logic [AW-1:0] slot_succ;
  logic          at_end;

  assign tail_sum   = (CW+1)'(front_idx) + (CW+1)'(occ);
  assign tail       = (tail_sum >= (CW+1)'(DEPTH)) ? AW'(tail_sum - (CW+1)'(DEPTH))
                                                   : AW'(tail_sum);
  assign front_prev = (front_idx == '0) ? LAST_SLOT : front_idx - AW'(1);
  assign front_succ = (front_idx == LAST_SLOT) ? '0 : front_idx + AW'(1);
  assign slot_succ  = (slot == LAST_SLOT) ? '0 : slot + AW'(1);
  assign at_end     = ((CW'(cnt) + CW'(1)) == occ);

  always_comb begin
    state_next     = state;
    front_idx_next = front_idx;
    occ_next       = occ;
    slot_next      = slot;
    cnt_next       = cnt;
    cur_next       = cur;
    pend_next      = pend;
    cmd_take       = 1'b0;
    mem_we         = 1'b0;
    mem_wa         = tail;
    res_push       = 1'b0;
    res            = pend;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_take = 1'b1;
          cur_next = cmd;
          unique case (cmd.cls)
            CLS_PUSH: begin
              if (occ == FULL_OCC) begin
                pend_next  = '{kind: K_FULL, data: '0, last: 1'b1};
                state_next = S_RES;
              end else begin
                mem_we   = 1'b1;
                occ_next = occ + CW'(1);
                if (cmd.at_front) begin
                  mem_wa         = front_prev;
                  front_idx_next = front_prev;
                end
              end
            end
            CLS_POP: begin
              if (occ == '0) begin
                pend_next  = '{kind: K_EMPTY, data: '0, last: 1'b1};
                state_next = S_RES;
              end else begin
                occ_next = occ - CW'(1);
                if (cmd.at_front) begin
                  front_idx_next = front_succ;
                end
              end
            end
            CLS_LIST, CLS_SEARCH: begin
              if (occ == '0) begin
                pend_next  = '{kind: (cmd.cls == CLS_LIST) ? K_EMPTY : K_ABSENT,
                               data: '0, last: 1'b1};
                state_next = S_RES;
              end else begin
                slot_next  = front_idx;
                cnt_next   = '0;
                state_next = S_RD;
              end
            end
            default: ;
          endcase
        end
      end
      S_RES: begin
        res_push = !res_full;
        if (!res_full) begin
          state_next = S_IDLE;
        end
      end
      S_RD: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (cur.cls == CLS_LIST) begin
          res = '{kind: K_ENTRY, data: rdata, last: !cur.with_count && at_end};
          if (!res_full) begin
            res_push = 1'b1;
            if (at_end) begin
              if (cur.with_count) begin
                pend_next  = '{kind: K_COUNT, data: WORD_W'(occ), last: 1'b1};
                state_next = S_RES;
              end else begin
                state_next = S_IDLE;
              end
            end else begin
              cnt_next   = cnt + AW'(1);
              slot_next  = slot_succ;
              state_next = S_RD;
            end
          end
        end else begin
          if (rdata == cur.value) begin
            pend_next  = '{kind: K_FOUND, data: '0, last: 1'b1};
            state_next = S_RES;
          end else if (at_end) begin
            pend_next  = '{kind: K_ABSENT, data: '0, last: 1'b1};
            state_next = S_RES;
          end else begin
            cnt_next   = cnt + AW'(1);
            slot_next  = slot_succ;
            state_next = S_RD;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= cmd.value;
    end
    rdata <= mem[slot];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      front_idx <= '0;
      occ       <= '0;
    end else begin
      state     <= state_next;
      front_idx <= front_idx_next;
      occ       <= occ_next;
    end
  end

  always_ff @(posedge clk) begin
    slot <= slot_next;
    cnt  <= cnt_next;
    cur  <= cur_next;
    pend <= pend_next;
  end

endmodule

FILE: hdl/bdq_outq.sv
module bdq_outq import bdq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic res_push,
  input  res_t res_in,
  output logic res_full,
  input  logic pop,
  output logic empty,
  output res_t res_out
);

  res_t       slots [2];
  logic       wp;
  logic       rp;
  logic [1:0] fill;
  logic       wr;
  logic       rd;

  assign res_full = (fill == 2'd2);
  assign empty    = (fill == 2'd0);
  assign res_out  = slots[rp];
  assign wr       = res_push && !res_full;
  assign rd       = pop && !empty;

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wp] <= res_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (wr) begin
        wp <= !wp;
      end
      if (rd) begin
        rp <= !rp;
      end
      if (wr && !rd) begin
        fill <= fill + 2'd1;
      end else if (rd && !wr) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

FILE: hdl/bounded_deque_with_search_core.sv
// Bounded double-ended queue of DEPTH signed 32-bit words in a ring memory,
// with push/pop at either end, display, count and search. Words enter through
// a two-deep command queue and results leave through a two-deep result queue,
// so both sides may stall freely. A successful push or pop is retired by the
// executor from its idle state once it reaches the head of the command queue.
// Display, count and search walk the held words one at a time (registered
// memory read, then compare or emit, emitting only while the result queue has
// room); search stops at the first match. Pop on empty, display or count on
// empty give one empty error, and a push on a full queue gives one full error.
module bounded_deque_with_search_core import bdq_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  output logic                     full,
  input  logic [ACT_W-1:0]         action,
  input  logic signed [WORD_W-1:0] value,
  output logic                     empty,
  input  logic                     pop,
  output logic [KIND_W-1:0]        kind,
  output logic signed [WORD_W-1:0] data,
  output logic                     last
);

  logic cmd_valid;
  logic cmd_take;
  cmd_t cmd;
  logic res_full;
  logic res_push;
  res_t res;
  res_t res_out;

  bdq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .action    (action),
    .value     (value),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .cmd       (cmd)
  );

  bdq_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .cmd       (cmd),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  bdq_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .res_in   (res),
    .res_full (res_full),
    .pop      (pop),
    .empty    (empty),
    .res_out  (res_out)
  );

  assign kind = res_out.kind;
  assign data = res_out.data;
  assign last = res_out.last;

endmodule

FILE: sim/tb_bounded_deque_with_search_core.sv
module tb_bounded_deque_with_search_core;
  import bdq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [ACT_W-1:0] ACT_UNUSED = 3'd7;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 100;

  logic                     clk;
  logic                     rst;
  logic                     push;
  logic                     full;
  logic [ACT_W-1:0]         action;
  logic signed [WORD_W-1:0] value;
  logic                     empty;
  logic                     pop;
  logic [KIND_W-1:0]        kind;
  logic signed [WORD_W-1:0] data;
  logic                     last;

  logic [WORD_W-1:0] held_words[$];
  res_t              pending_results[$];
  int                err_count = 0;
  int                send_idle_pct = 0;
  int                recv_stall_pct = 0;
  int                hold_off = 0;
  int                idle_cycles = 0;

  bounded_deque_with_search_core dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .action (action),
    .value  (value),
    .empty  (empty),
    .pop    (pop),
    .kind   (kind),
    .data   (data),
    .last   (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic res_t make_result(logic [KIND_W-1:0] k, logic [WORD_W-1:0] d,
                                       logic l);
    res_t r;
    r.kind = k;
    r.data = d;
    r.last = l;
    return r;
  endfunction

  // Update the deque image and queue the words this action must produce.
  task automatic apply_action(input logic [ACT_W-1:0] act, input logic [WORD_W-1:0] val);
    bit hit;
    int n;
    hit = 1'b0;
    n = held_words.size();
    case (act)
      ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
        if (n >= DEPTH) begin
          pending_results.push_back(make_result(K_FULL, '0, 1'b1));
        end else if (act == ACT_PUSH_FRONT) begin
          held_words.push_front(val);
        end else begin
          held_words.push_back(val);
        end
      end
      ACT_POP_FRONT, ACT_POP_BACK: begin
        if (n == 0) begin
          pending_results.push_back(make_result(K_EMPTY, '0, 1'b1));
        end else if (act == ACT_POP_FRONT) begin
          void'(held_words.pop_front());
        end else begin
          void'(held_words.pop_back());
        end
      end
      ACT_DISPLAY, ACT_COUNT: begin
        if (n == 0) begin
          pending_results.push_back(make_result(K_EMPTY, '0, 1'b1));
        end else begin
          for (int i = 0; i < n; i++) begin
            pending_results.push_back(make_result(K_ENTRY, held_words[i],
                                                  act == ACT_DISPLAY && i == n - 1));
          end
          if (act == ACT_COUNT) begin
            pending_results.push_back(make_result(K_COUNT, WORD_W'(n), 1'b1));
          end
        end
      end
      ACT_SEARCH: begin
        foreach (held_words[i]) begin
          if (held_words[i] == val) hit = 1'b1;
        end
        pending_results.push_back(make_result(hit ? K_FOUND : K_ABSENT, '0, 1'b1));
      end
      default: begin
      end
    endcase
  endtask

  task automatic send_word(input logic [ACT_W-1:0] act, input logic [WORD_W-1:0] val);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      action <= ACT_W'($urandom);
      value <= $urandom;
      @(negedge clk);
    end
    push <= 1'b1;
    action <= act;
    value <= val;
    @(posedge clk);
    while (full) @(posedge clk);
    apply_action(act, val);
  endtask

  task automatic drop_push();
    @(negedge clk);
    push <= 1'b0;
  endtask

  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(7))
      0: return '0;
      1: return 32'h7fff_ffff;
      2: return 32'h8000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  task automatic test_directed();
    send_word(ACT_POP_FRONT, '0);
    send_word(ACT_POP_BACK, '0);
    send_word(ACT_DISPLAY, '0);
    send_word(ACT_COUNT, '0);
    send_word(ACT_SEARCH, '0);
    send_word(ACT_UNUSED, 32'h1234_5678);
    send_word(ACT_PUSH_BACK, 32'h7fff_ffff);
    send_word(ACT_PUSH_FRONT, 32'h8000_0000);
    send_word(ACT_PUSH_BACK, '0);
    send_word(ACT_PUSH_FRONT, 32'hffff_ffff);
    send_word(ACT_DISPLAY, '0);
    send_word(ACT_COUNT, '0);
    send_word(ACT_SEARCH, '0);
    send_word(ACT_SEARCH, 32'h8000_0000);
    send_word(ACT_SEARCH, 32'd12345);
    send_word(ACT_UNUSED, '0);
    send_word(ACT_POP_BACK, '0);
    send_word(ACT_DISPLAY, '0);
    send_word(ACT_POP_FRONT, '0);
    send_word(ACT_POP_FRONT, '0);
    send_word(ACT_DISPLAY, '0);
    send_word(ACT_POP_FRONT, '0);
    send_word(ACT_DISPLAY, '0);
    send_word(ACT_POP_BACK, '0);
    drop_push();
  endtask

  // Hold the result side while pushing past capacity, then walk a full deque.
  task automatic test_pressure();
    int extra;
    extra = DEPTH - held_words.size() + 4;
    hold_off = 300;
    for (int i = 0; i < extra; i++) send_word(ACT_PUSH_BACK, rand_word());
    send_word(ACT_PUSH_FRONT, 32'h7fff_ffff);
    send_word(ACT_COUNT, '0);
    send_word(ACT_SEARCH, held_words[DEPTH - 1]);
    send_word(ACT_SEARCH, held_words[DEPTH / 2]);
    send_word(ACT_DISPLAY, '0);
    for (int i = 0; i < DEPTH / 2; i++) begin
      send_word(ACT_POP_FRONT, '0);
      send_word(ACT_PUSH_FRONT, rand_word());
      send_word(ACT_POP_BACK, '0);
    end
    send_word(ACT_COUNT, '0);
    while (held_words.size() > 0) send_word(ACT_POP_FRONT, '0);
    send_word(ACT_COUNT, '0);
    drop_push();
  endtask

  task automatic test_random(input int n_items);
    logic [ACT_W-1:0]  act;
    logic [WORD_W-1:0] val;
    bit                filling;
    int                r;
    filling = 1'b1;
    for (int i = 0; i < n_items; i++) begin
      if (held_words.size() >= DEPTH) filling = 1'b0;
      else if (held_words.size() == 0) filling = 1'b1;
      else if ($urandom_range(39) == 0) filling = ~filling;
      r = $urandom_range(99);
      val = rand_word();
      if (r < 2) begin
        act = ACT_UNUSED;
      end else if (r < 12) begin
        act = ACT_SEARCH;
        if (held_words.size() > 0 && $urandom_range(1)) begin
          val = held_words[$urandom_range(held_words.size() - 1)];
        end
      end else if (r < 18) begin
        act = ACT_DISPLAY;
      end else if (r < 24) begin
        act = ACT_COUNT;
      end else if ((r < 80) == filling) begin
        act = $urandom_range(1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
      end else begin
        act = $urandom_range(1) ? ACT_POP_FRONT : ACT_POP_BACK;
      end
      send_word(act, val);
    end
    drop_push();
  endtask

  initial begin
    rst = 1'b1;
    push = 1'b0;
    action = '0;
    value = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    set_idling(0, 0);
    test_directed();
    test_pressure();
    test_random(92);
    set_idling(65, 0);
    test_random(92);
    set_idling(0, 65);
    test_random(92);
    set_idling(24, 24);
    test_random(92);
    set_idling(0, 0);

    while (pending_results.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("bounded_deque_with_search_core test passed");
    end else begin
      $display("bounded_deque_with_search_core test failed");
    end
    $finish;
  end

  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        pop <= 1'b0;
        hold_off--;
      end else begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin : result_check
    res_t want;
    if (!rst && pop && !empty) begin
      if (pending_results.size() == 0) begin
        $error("unexpected word: kind %0d data %0d last %0b", kind, data, last);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        if (kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, kind);
          err_count++;
        end
        if (data !== want.data) begin
          $error("data: expected %0d, got %0d", $signed(want.data), data);
          err_count++;
        end
        if (last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, last);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("bounded_deque_with_search_core test failed");
      $finish;
    end
  end

endmodule

FILE: bounded_deque_with_search_core.f
hdl/bdq_pkg.sv
hdl/bdq_front.sv
hdl/bdq_back.sv
hdl/bdq_outq.sv
hdl/bounded_deque_with_search_core.sv
sim/tb_bounded_deque_with_search_core.sv
